>>> src/assert_macros.svh
// Assertion macros for the checker file of this block.
// No dependencies; take in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge out of reset.
`define SLX_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that also runs through reset.
`define SLX_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> src/slxfr_pkg.sv
// Types and constants of the sync/length/XOR frame receiver.
// No dependencies; used by the core, the input and result registers, the top level and the checker.
`timescale 1ns / 1ps

package slxfr_pkg;

  // Input word kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Result event codes
  localparam logic [2:0] EV_PAYLOAD   = 3'd0;
  localparam logic [2:0] EV_GOOD      = 3'd1;
  localparam logic [2:0] EV_BAD_CSUM  = 3'd2;
  localparam logic [2:0] EV_TOO_LONG  = 3'd3;
  localparam logic [2:0] EV_STALE     = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_SYNC_FIRST    = 2'd0;
  localparam logic [1:0] CFG_SYNC_SECOND   = 2'd1;
  localparam logic [1:0] CFG_PAYLOAD_LIMIT = 2'd2;
  localparam logic [1:0] CFG_STALE_TICKS   = 2'd3;

  localparam logic [16:0] IDLE_MAX = 17'h1FFFF;

  typedef enum logic [7:0] {
    PH_HUNT    = 8'b0000_0001,
    PH_SYNC2   = 8'b0000_0010,
    PH_TYPE    = 8'b0000_0100,
    PH_LEN_HI  = 8'b0000_1000,
    PH_LEN_LO  = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_CHECK   = 8'b0100_0000,
    PH_DISCARD = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  frame_type;
    logic [7:0]  data_byte;
    logic [15:0] byte_index;
    logic [15:0] frame_length;
  } result_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] payload_limit;
    logic [15:0] stale_ticks;
  } cfg_t;

endpackage

>>> src/slxfr_item_if.sv
// Input channel: one received byte or one time tick per word.
// No dependencies.
`timescale 1ns / 1ps

interface slxfr_item_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] byte_value;

  modport source (output valid, kind, byte_value, input ready);
  modport sink (input valid, kind, byte_value, output ready);
  modport monitor (input valid, ready, kind, byte_value);
endinterface

>>> src/slxfr_result_if.sv
// Result channel: frame events and payload bytes.
// No dependencies.
`timescale 1ns / 1ps

interface slxfr_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  frame_type;
  logic [7:0]  data_byte;
  logic [15:0] byte_index;
  logic [15:0] frame_length;

  modport source (output valid, event_res, frame_type, data_byte, byte_index,
                  frame_length, input ready);
  modport sink (input valid, event_res, frame_type, data_byte, byte_index,
                frame_length, output ready);
  modport monitor (input valid, ready, event_res, frame_type, data_byte, byte_index,
                   frame_length);
endinterface

>>> src/slxfr_in_reg.sv
// Input register of the frame receiver: holds one word until the core takes it.
// Depends on slxfr_pkg.
`timescale 1ns / 1ps

module slxfr_in_reg import slxfr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  take,
  output logic  held_valid,
  output item_t held_item
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

>>> src/slxfr_core.sv
// Frame parser: phase register, running XOR, counters and the result logic.
// Depends on slxfr_pkg.
`timescale 1ns / 1ps

module slxfr_core import slxfr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    take,
  input  item_t   item,
  input  cfg_t    cfg,
  output logic    res_valid,
  output result_t res
);

  phase_t      phase, phase_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [7:0]  held_type, held_type_next;
  logic [15:0] held_length, held_length_next;
  logic [16:0] byte_count, byte_count_next;
  logic [16:0] idle_ticks, idle_ticks_next;

  logic [16:0] count_inc;
  logic [15:0] len_lo;
  logic [7:0]  b;

  assign b         = item.byte_value;
  assign count_inc = byte_count + 17'd1;
  assign len_lo    = {held_length[15:8], b};

  always_comb begin
    phase_next       = phase;
    running_xor_next = running_xor;
    held_type_next   = held_type;
    held_length_next = held_length;
    byte_count_next  = byte_count;
    idle_ticks_next  = idle_ticks;
    res_valid        = 1'b0;
    res.event_res    = EV_PAYLOAD;
    res.data_byte    = 8'd0;
    res.byte_index   = 16'd0;

    if (item.kind == KIND_TICK) begin
      if (idle_ticks != IDLE_MAX) begin
        idle_ticks_next = idle_ticks + 17'd1;
      end
      if (phase != PH_HUNT && idle_ticks_next > {1'b0, cfg.stale_ticks}) begin
        phase_next    = PH_HUNT;
        res_valid     = 1'b1;
        res.event_res = EV_STALE;
      end
    end else begin
      idle_ticks_next = 17'd0;
      case (phase)
        PH_HUNT: begin
          if (b == cfg.sync_first) phase_next = PH_SYNC2;
        end
        PH_SYNC2: begin
          if (b == cfg.sync_second) begin
            phase_next       = PH_TYPE;
            running_xor_next = 8'd0;
            held_type_next   = 8'd0;
            held_length_next = 16'd0;
            byte_count_next  = 17'd0;
          end else begin
            phase_next = PH_HUNT;
          end
        end
        PH_TYPE: begin
          held_type_next   = b;
          running_xor_next = b;
          phase_next       = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          held_length_next = {b, 8'd0};
          running_xor_next = running_xor ^ b;
          phase_next       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          held_length_next = len_lo;
          running_xor_next = running_xor ^ b;
          byte_count_next  = 17'd0;
          if (len_lo > cfg.payload_limit) begin
            phase_next    = PH_DISCARD;
            res_valid     = 1'b1;
            res.event_res = EV_TOO_LONG;
          end else if (len_lo == 16'd0) begin
            phase_next = PH_CHECK;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          running_xor_next = running_xor ^ b;
          byte_count_next  = count_inc;
          if (count_inc >= {1'b0, held_length}) phase_next = PH_CHECK;
          res_valid      = 1'b1;
          res.event_res  = EV_PAYLOAD;
          res.data_byte  = b;
          res.byte_index = byte_count[15:0];
        end
        PH_CHECK: begin
          phase_next    = PH_HUNT;
          res_valid     = 1'b1;
          res.event_res = (b == running_xor) ? EV_GOOD : EV_BAD_CSUM;
        end
        PH_DISCARD: begin
          byte_count_next = count_inc;
          if (count_inc >= {1'b0, held_length} + 17'd1) phase_next = PH_HUNT;
        end
        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end

    res.frame_type   = held_type_next;
    res.frame_length = held_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      running_xor <= 8'd0;
      held_type   <= 8'd0;
      held_length <= 16'd0;
      byte_count  <= 17'd0;
      idle_ticks  <= 17'd0;
    end else if (take) begin
      phase       <= phase_next;
      running_xor <= running_xor_next;
      held_type   <= held_type_next;
      held_length <= held_length_next;
      byte_count  <= byte_count_next;
      idle_ticks  <= idle_ticks_next;
    end
  end

endmodule

>>> src/slxfr_out_reg.sv
// Result register: holds one result word until the sink takes it.
// Depends on slxfr_pkg.
`timescale 1ns / 1ps

module slxfr_out_reg import slxfr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  logic    load_valid,
  input  result_t load_res,
  output logic    free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= load_valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      out_res <= load_res;
    end
  end

endmodule

>>> src/sync_length_xor_frame_receiver.sv
// Frame receiver for sync word, 16-bit length prefix and XOR checksum.
// A word is registered in the input register on acceptance; its result, if any, is
// registered in the result register when the core takes the word.
// Throughput: one word per cycle while results are taken.
// Reset (rst, synchronous, active high): hunting for the first sync byte, all
// counters clear, registers back to 0xEF, 0xAA, 1024 and 100.
`timescale 1ns / 1ps

module sync_length_xor_frame_receiver import slxfr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [15:0] cfg_wdata,
  slxfr_item_if.sink     item,
  slxfr_result_if.source result
);

  // Config regs: written by the user only while no word is in flight; unchecked.
  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_first    <= 8'hEF;
      cfg.sync_second   <= 8'hAA;
      cfg.payload_limit <= 16'd1024;
      cfg.stale_ticks   <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SYNC_FIRST:    cfg.sync_first    <= cfg_wdata[7:0];
        CFG_SYNC_SECOND:   cfg.sync_second   <= cfg_wdata[7:0];
        CFG_PAYLOAD_LIMIT: cfg.payload_limit <= cfg_wdata;
        CFG_STALE_TICKS:   cfg.stale_ticks   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline control: the held word is consumed whenever the result register
  // can take whatever it produces (including nothing).
  item_t   in_item, held_item;
  logic    held_valid;
  logic    take;
  logic    free;
  logic    core_valid;
  result_t core_res, out_res;

  assign in_item.kind       = item.kind;
  assign in_item.byte_value = item.byte_value;
  assign take               = held_valid && free;

  slxfr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (item.valid),
    .in_ready   (item.ready),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // Phase machine and XOR/count update: all state changes on take.
  slxfr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (held_item),
    .cfg       (cfg),
    .res_valid (core_valid),
    .res       (core_res)
  );

  slxfr_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (take),
    .load_valid (core_valid),
    .load_res   (core_res),
    .free       (free),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_res    (out_res)
  );

  assign result.event_res    = out_res.event_res;
  assign result.frame_type   = out_res.frame_type;
  assign result.data_byte    = out_res.data_byte;
  assign result.byte_index   = out_res.byte_index;
  assign result.frame_length = out_res.frame_length;

endmodule

>>> src/slxfr_checker.sv
// Port-level checks of the frame receiver, bound to the top level.
// Depends on slxfr_pkg, the channel interfaces and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module slxfr_checker import slxfr_pkg::*; (
  input logic clk,
  input logic rst,
  slxfr_item_if.sink     item,
  slxfr_result_if.source result
);

  `SLX_ASSERT(a_hold, clk, rst,
    result.valid && !result.ready |=> result.valid && $stable(result.event_res)
    && $stable(result.byte_index), "result word dropped or changed while stalled")
  `SLX_ASSERT(a_data_zero, clk, rst,
    result.valid && result.event_res != EV_PAYLOAD |->
    result.data_byte == 8'd0 && result.byte_index == 16'd0, "non-payload event carries data")
  `SLX_ASSERT(a_index_range, clk, rst,
    result.valid && result.event_res == EV_PAYLOAD |->
    result.byte_index < result.frame_length, "payload index beyond declared length")
  `SLX_ASSERT(a_accept_free, clk, rst,
    !result.valid || result.ready |-> item.ready, "input blocked with result side free")
  `SLX_ASSERT_ALWAYS(a_reset_quiet, clk, $past(rst) |-> !result.valid,
    "result valid straight after reset")

endmodule

bind sync_length_xor_frame_receiver slxfr_checker u_checker (
  .clk    (clk),
  .rst    (rst),
  .item   (item),
  .result (result)
);
